### rtl/core/four_level_page_table_walk_assert.svh
// assertion helpers for the page table walker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALK_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALK_ASSERT_SVH

// same-cycle implication
`define PGW_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgw assertion failed");

// next-cycle implication
`define PGW_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgw assertion failed");

`endif

### rtl/core/pgw_pkg.sv
package pgw_pkg;

   localparam int TABLE_COUNT       = 16;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int STORE_WORDS       = TABLE_COUNT * ENTRIES_PER_TABLE;
   localparam int IDX_W             = 9;
   localparam int TBL_W             = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int WADDR_W           = TBL_W + IDX_W;
   localparam int VA_W              = 48;
   localparam int DATA_W            = 64;
   localparam int PAGE_SHIFT        = 12;
   localparam int FRAME_W           = VA_W - PAGE_SHIFT;
   localparam int ROOT_W            = 4;

   localparam logic       CMD_WRITE     = 1'b0;
   localparam logic       CMD_TRANSLATE = 1'b1;
   localparam logic [1:0] LEVEL_LAST    = 2'd3;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_OUTSIDE = 2'd2
   } pgw_status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK
   } pgw_state_type;

   typedef struct packed {
      logic                we;
      logic                re;
      logic [WADDR_W-1:0]  addr;
      logic [DATA_W-1:0]   wdata;
   } pgw_mem_req_type;

endpackage

### rtl/core/pgw_store.sv
module pgw_store
   import pgw_pkg::*;
(
   input  logic                  clock,
   input  pgw_mem_req_type       mem_req,
   output logic [DATA_W-1:0]     rd_data
);

   logic [DATA_W-1:0] mem_ff [STORE_WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= mem_ff[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/four_level_page_table_walk.sv
// channel   dir  handshake             payload
// req_      in   req_valid/req_stall   req_command, req_address, req_write_data
// rsp_      out  rsp_valid/rsp_stall   rsp_translated_addr, rsp_status, rsp_leaf_valid
// csr_      in   csr_valid/csr_ready   csr_root_table
//
// A write request is answered straight from the idle state; a translate reads one
// descriptor per level from the single-port store, then forms the result, and
// stops early on a fault. After reset the store, TABLE_COUNT*512 words (8192), is
// cleared one word a cycle, during which req_stall is high.
// A stalled response holds the walk at its last step; csr writes are always taken.
module four_level_page_table_walk
   import pgw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [VA_W-1:0]     req_address,
   input  logic [DATA_W-1:0]   req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [VA_W-1:0]     rsp_translated_addr,
   output logic [1:0]          rsp_status,
   output logic                rsp_leaf_valid,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ROOT_W-1:0]   csr_root_table
);

   pgw_state_type       state_ff, state_in;
   logic [1:0]          level_ff, level_in;
   logic [VA_W-1:0]     va_ff, va_in;
   logic [WADDR_W-1:0]  clr_ff, clr_in;
   logic [ROOT_W-1:0]   root_ff;
   logic                rsp_valid_ff;
   logic [VA_W-1:0]     rsp_pa_ff, rsp_pa_in;
   pgw_status_type      rsp_status_ff, rsp_status_in;
   logic                rsp_leaf_ff, rsp_leaf_in;
   logic                rsp_load;

   pgw_mem_req_type     mem_req;
   logic [DATA_W-1:0]   rd_data;

   logic                rsp_free;
   logic                accept_ok;
   logic                req_accept;
   logic [FRAME_W-1:0]  root_frame;
   logic                root_out;
   logic [FRAME_W-1:0]  wr_frame;
   logic [FRAME_W-1:0]  desc_frame;
   logic [1:0]          next_level;
   logic [IDX_W-1:0]    next_idx;

   pgw_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign accept_ok  = (state_ff == S_IDLE) && rsp_free;
   assign req_stall  = !accept_ok;
   assign req_accept = req_valid && accept_ok;
   assign csr_ready  = 1'b1;

   assign root_frame = FRAME_W'(root_ff);
   assign root_out   = root_frame >= FRAME_W'(TABLE_COUNT);
   assign wr_frame   = req_address[VA_W-1:PAGE_SHIFT];
   assign desc_frame = rd_data[VA_W-1:PAGE_SHIFT];
   assign next_level = 2'(level_ff + 2'd1);

   always_comb begin
      case (next_level)
         2'd0:    next_idx = va_ff[47:39];
         2'd1:    next_idx = va_ff[38:30];
         2'd2:    next_idx = va_ff[29:21];
         2'd3:    next_idx = va_ff[20:12];
         default: next_idx = va_ff[47:39];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         level_ff     <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         level_ff <= level_in;
         if (csr_valid && csr_ready) begin
            root_ff <= csr_root_table;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      va_ff <= va_in;
      if (rsp_load) begin
         rsp_pa_ff     <= rsp_pa_in;
         rsp_status_ff <= rsp_status_in;
         rsp_leaf_ff   <= rsp_leaf_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      va_in         = va_ff;
      clr_in        = clr_ff;
      mem_req       = '0;
      rsp_load      = 1'b0;
      rsp_pa_in     = '0;
      rsp_status_in = ST_OK;
      rsp_leaf_in   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = clr_ff;
            clr_in       = WADDR_W'(clr_ff + 1'b1);
            if (clr_ff == WADDR_W'(STORE_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               rsp_load = 1'b1;
               if (req_command == CMD_WRITE) begin
                  if (wr_frame >= FRAME_W'(TABLE_COUNT)) begin
                     rsp_status_in = ST_OUTSIDE;
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.addr  = {wr_frame[TBL_W-1:0], req_address[11:3]};
                     mem_req.wdata = req_write_data;
                  end
               end else if (root_out) begin
                  rsp_status_in = ST_OUTSIDE;
               end else begin
                  rsp_load     = 1'b0;
                  mem_req.re   = 1'b1;
                  mem_req.addr = {root_frame[TBL_W-1:0], req_address[47:39]};
                  va_in        = req_address;
                  level_in     = '0;
                  state_in     = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (level_ff == LEVEL_LAST) begin
               if (rsp_free) begin
                  rsp_load    = 1'b1;
                  rsp_pa_in   = {desc_frame, va_ff[PAGE_SHIFT-1:0]};
                  rsp_leaf_in = rd_data[0];
                  state_in    = S_IDLE;
               end
            end else if (!rd_data[0]) begin
               if (rsp_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_INVALID;
                  state_in      = S_IDLE;
               end
            end else if (desc_frame >= FRAME_W'(TABLE_COUNT)) begin
               if (rsp_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_OUTSIDE;
                  state_in      = S_IDLE;
               end
            end else begin
               mem_req.re   = 1'b1;
               mem_req.addr = {desc_frame[TBL_W-1:0], next_idx};
               level_in     = next_level;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_translated_addr = rsp_pa_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_leaf_valid      = rsp_leaf_ff;

`include "four_level_page_table_walk_assert.svh"

   `PGW_ASSERT_IMP(a_clear_blocks, clock, reset, state_ff == S_CLEAR, req_stall)
   `PGW_ASSERT_IMP(a_fault_zero, clock, reset, rsp_valid && (rsp_status != ST_OK),
                   (rsp_translated_addr == '0) && !rsp_leaf_valid)
   `PGW_ASSERT_NXT(a_walk_start, clock, reset,
                   req_accept && (req_command == CMD_TRANSLATE) && !root_out,
                   (state_ff == S_WALK) && (level_ff == 2'd0))

endmodule

### tb/sv/testbench.sv
module testbench
   import pgw_pkg::*;
();

   typedef struct {
      bit                is_root_write;
      logic              command;
      logic [VA_W-1:0]   address;
      logic [DATA_W-1:0] write_data;
      logic [ROOT_W-1:0] root;
      int                gap;
   } plan_entry_type;

   typedef struct {
      logic [VA_W-1:0] translated_addr;
      pgw_status_type  status;
      logic            leaf_valid;
   } walk_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_command = CMD_WRITE;
   logic [VA_W-1:0]   req_address = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [VA_W-1:0]   rsp_translated_addr;
   logic [1:0]        rsp_status;
   logic              rsp_leaf_valid;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [ROOT_W-1:0] csr_root_table = '0;

   plan_entry_type    request_plan[$];
   walk_result_type   walk_results[$];
   logic [VA_W-1:0]   mapped_pages[$];
   logic [DATA_W-1:0] descriptor_image [0:STORE_WORDS-1];
   logic [ROOT_W-1:0] root_setting = '0;

   int requests_sent = 0;
   int responses_seen = 0;
   int error_count = 0;
   int item_count = 0;
   bit calm_gaps = 0;
   int gap_left = 0;
   bit gap_armed = 0;
   int hold_left = 0;

   four_level_page_table_walk DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_address         (req_address),
      .req_write_data      (req_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_translated_addr (rsp_translated_addr),
      .rsp_status          (rsp_status),
      .rsp_leaf_valid      (rsp_leaf_valid),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_root_table      (csr_root_table)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stores a descriptor or walks the four levels against the shadow store
   function automatic walk_result_type walk_or_store(plan_entry_type r);
      walk_result_type res;
      logic [35:0]  frame;
      logic [63:0]  desc;
      logic [8:0]   idx;
      int           level;
      res.translated_addr = '0;
      res.status = ST_OK;
      res.leaf_valid = 1'b0;
      desc = '0;
      if (r.command == CMD_WRITE) begin
         frame = r.address[47:12];
         if (frame >= TABLE_COUNT)
            res.status = ST_OUTSIDE;
         else
            descriptor_image[frame * ENTRIES_PER_TABLE + r.address[11:3]] = r.write_data;
         return res;
      end
      frame = root_setting;
      for (level = 0; level < 4; level++) begin
         idx = r.address[39 - 9 * level +: 9];
         if (frame >= TABLE_COUNT) begin
            res.status = ST_OUTSIDE;
            return res;
         end
         desc = descriptor_image[frame * ENTRIES_PER_TABLE + idx];
         if (level < 3) begin
            if (!desc[0]) begin
               res.status = ST_INVALID;
               return res;
            end
            frame = desc[47:12];
         end
      end
      res.translated_addr = {desc[47:12], r.address[11:0]};
      res.leaf_valid = desc[0];
      return res;
   endfunction

   function automatic int draw_gap();
      if (item_count % 40 == 0)
         calm_gaps = ($urandom_range(0, 2) == 0);
      return calm_gaps ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic queue_item(logic cmd, logic [VA_W-1:0] addr, logic [DATA_W-1:0] data);
      plan_entry_type e;
      e.is_root_write = 0;
      e.command = cmd;
      e.address = addr;
      e.write_data = data;
      e.root = '0;
      e.gap = draw_gap();
      request_plan.push_back(e);
      item_count++;
   endtask

   task automatic queue_root(logic [ROOT_W-1:0] r);
      plan_entry_type e;
      e.is_root_write = 1;
      e.command = CMD_WRITE;
      e.address = '0;
      e.write_data = '0;
      e.root = r;
      e.gap = draw_gap();
      request_plan.push_back(e);
   endtask

   // builds one four-level path for va, sometimes broken, then translates through it
   task automatic map_and_walk(logic [ROOT_W-1:0] root, logic [VA_W-1:0] va);
      logic [3:0]  tbl;
      logic [3:0]  nxt;
      logic [63:0] desc;
      int          fault_at;
      int          level;
      fault_at = $urandom_range(0, 11);
      tbl = root;
      for (level = 0; level < 4; level++) begin
         nxt = 4'($urandom);
         desc = {$urandom, $urandom};
         if (level < 3) begin
            desc[47:12] = {32'd0, nxt};
            desc[0] = (fault_at != level);
            if (fault_at == level + 3)
               desc[47:12] = {32'($urandom_range(1, 32'hFFFF_FFFF)), nxt};
         end else begin
            desc[0] = ($urandom_range(0, 4) != 0);
         end
         queue_item(CMD_WRITE, {32'd0, tbl, va[39 - 9 * level +: 9], 3'($urandom)}, desc);
         tbl = nxt;
      end
      repeat ($urandom_range(1, 3))
         queue_item(CMD_TRANSLATE, {va[47:12], 12'($urandom)}, {$urandom, $urandom});
      if (fault_at > 5)
         mapped_pages.push_back(va);
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      logic next_valid;
      logic next_csr;
      logic accepted;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         root_setting = '0;
         gap_armed = 0;
         foreach (descriptor_image[i])
            descriptor_image[i] = '0;
      end else begin
         accepted = 1'b0;
         next_valid = req_valid;
         next_csr = csr_valid;
         if (req_valid && !req_stall) begin
            walk_results.push_back(walk_or_store(request_plan.pop_front()));
            requests_sent <= requests_sent + 1;
            accepted = 1'b1;
            next_valid = 1'b0;
            gap_armed = 0;
         end
         if (csr_valid && csr_ready) begin
            root_setting = csr_root_table;
            void'(request_plan.pop_front());
            next_csr = 1'b0;
            gap_armed = 0;
         end
         if (!next_valid && !next_csr && request_plan.size() > 0) begin
            if (!gap_armed) begin
               gap_left = request_plan[0].gap;
               gap_armed = 1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else if (!request_plan[0].is_root_write) begin
               req_command <= request_plan[0].command;
               req_address <= request_plan[0].address;
               req_write_data <= request_plan[0].write_data;
               next_valid = 1'b1;
            end else if (!accepted && requests_sent == responses_seen) begin
               // root changes only with nothing in flight
               csr_root_table <= request_plan[0].root;
               next_csr = 1'b1;
            end
         end
         req_valid <= next_valid;
         csr_valid <= next_csr;
      end
   end

   always @(posedge clock) begin
      walk_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen <= responses_seen + 1;
            if (walk_results.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = walk_results.pop_front();
               if (rsp_translated_addr !== want.translated_addr)
                  report_mismatch($sformatf("translated_addr %h, want %h",
                     rsp_translated_addr, want.translated_addr));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
               if (rsp_leaf_valid !== want.leaf_valid)
                  report_mismatch($sformatf("leaf_valid %b, want %b",
                     rsp_leaf_valid, want.leaf_valid));
            end
            hold_left = ((responses_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 14);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int              phase;
      int              pick;
      int              phase_end;
      logic [ROOT_W-1:0] root;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      queue_root('0);
      queue_item(CMD_TRANSLATE, '0, '0);
      queue_item(CMD_WRITE, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(CMD_WRITE, 48'h0000_0001_0000, '0);
      queue_item(CMD_WRITE, 48'h0000_0000_FFFF, {$urandom, $urandom});
      // all-ones address through the last entry of tables 0, 15, 14 and 13
      queue_item(CMD_WRITE, {32'd0, 4'd0, 9'h1FF, 3'd0}, {16'hFFFF, 36'd15, 12'hFFF});
      queue_item(CMD_WRITE, {32'd0, 4'd15, 9'h1FF, 3'd5}, {16'h0000, 36'd14, 12'h001});
      queue_item(CMD_WRITE, {32'd0, 4'd14, 9'h1FF, 3'd0}, {16'h8000, 36'd13, 12'h801});
      queue_item(CMD_WRITE, {32'd0, 4'd13, 9'h1FF, 3'd7}, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_item(CMD_TRANSLATE, 48'hFFFF_FFFF_F000, '0);
      // leaf with valid bit clear
      queue_item(CMD_WRITE, {32'd0, 4'd13, 9'h1FF, 3'd0}, {16'h0000, 36'h1_2345_6789, 12'hFFE});
      queue_item(CMD_TRANSLATE, 48'hFFFF_FFFF_F123, '0);
      // level 2 points past the store
      queue_item(CMD_WRITE, {32'd0, 4'd14, 9'h1FF, 3'd0}, {16'h0000, 36'd16, 12'h001});
      queue_item(CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0);
      queue_item(CMD_WRITE, {32'd0, 4'd15, 9'h1FF, 3'd0}, 64'hFFFF_FFFF_FFFF_FFFE);
      queue_item(CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0);
      // every level through entry 0 of table 0
      queue_item(CMD_WRITE, '0, 64'h1);
      queue_item(CMD_TRANSLATE, 48'h0000_0000_0ABC, '0);

      for (phase = 0; phase < 5; phase++) begin
         if (phase % 2 == 1)
            root = 4'($urandom_range(1, 14));
         else
            root = (phase % 4 == 0) ? 4'd15 : 4'd0;
         queue_root(root);
         mapped_pages.delete();
         phase_end = item_count + 100;
         while (item_count < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
               map_and_walk(root, {$urandom, 16'($urandom)});
            else if (pick < 70 && mapped_pages.size() > 0)
               queue_item(CMD_TRANSLATE,
                  {mapped_pages[$urandom_range(0, mapped_pages.size() - 1)][47:12],
                   12'($urandom)}, {$urandom, $urandom});
            else if (pick < 80)
               queue_item(CMD_WRITE, {32'd0, 16'($urandom)}, {$urandom, $urandom});
            else if (pick < 90)
               queue_item(CMD_WRITE, {$urandom, 16'($urandom)}, {$urandom, $urandom});
            else
               queue_item(CMD_TRANSLATE, {$urandom, 16'($urandom)}, {$urandom, $urandom});
         end
      end

      while (request_plan.size() != 0 || walk_results.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("four_level_page_table_walk regression: pass");
      else
         $display("four_level_page_table_walk regression: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("four_level_page_table_walk regression: fail");
      $finish;
   end

endmodule
